@@ rtl/core/hax_pkg.sv @@
`timescale 1ns / 1ps

package hax_pkg;

    // Field widths fixed by the data formats
    localparam int COORD_W    = 23;                // Q14.8 coordinate
    localparam int DIFF_W     = COORD_W + 1;       // upper minus lower bound
    localparam int CFG_SIZE_W = 7;                 // grid size registers
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 23;
    localparam int M_DATA_W   = ((3 * COORD_W + 7) / 8) * 8;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_LOWER    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_UPPER    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LOWER    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_UPPER    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_LOWER    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_UPPER    = 4'd7;

    // Reset values of the configuration registers
    localparam logic [CFG_SIZE_W-1:0]     SIZE_RST     = 7'd64;
    localparam logic signed [COORD_W-1:0] BOUND_LO_RST = -23'sd256000;
    localparam logic signed [COORD_W-1:0] BOUND_HI_RST = 23'sd256000;

    // Saturation limits of a coordinate
    localparam int COORD_MIN = -4194304;
    localparam int COORD_MAX = 4194303;

    // Job queue between accumulator and mapper
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Axis codes of the mapper
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_lo;
        logic signed [COORD_W-1:0] x_hi;
        logic signed [COORD_W-1:0] y_lo;
        logic signed [COORD_W-1:0] y_hi;
        logic signed [COORD_W-1:0] z_lo;
        logic signed [COORD_W-1:0] z_hi;
    } bounds_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_ADD,
        BK_SEND
    } back_state_t;

endpackage

@@ rtl/core/hax_queue.sv @@
`timescale 1ns / 1ps

module hax_queue #(
    parameter int WIDTH = 22
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = hax_pkg::QUEUE_PTR_W;
    localparam int CNT_W = $clog2(hax_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [hax_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(hax_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(hax_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(hax_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store a job on each push
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> push_ready)
        else $error("job pushed into a full queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(hax_pkg::QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

endmodule

@@ rtl/core/hax_front.sv @@
`timescale 1ns / 1ps

module hax_front #(
    parameter int SCORE_BITS = 16,
    parameter int IDX_W      = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SCORE_BITS-1:0] score,
    input  logic [IDX_W-1:0]      grid_w,
    input  logic [IDX_W-1:0]      grid_d,
    output logic                  push_valid,
    input  logic                  push_ready,
    output logic [3*IDX_W:0]      push_data
);

    logic signed [SCORE_BITS-1:0] best_score_reg, best_score_next;
    logic [IDX_W-1:0]             best_col_reg, best_col_next;
    logic [IDX_W-1:0]             best_row_reg, best_row_next;
    logic [IDX_W-1:0]             best_slice_reg, best_slice_next;
    logic                         have_best_reg, have_best_next;
    logic [IDX_W-1:0]             col_reg, col_next;
    logic [IDX_W-1:0]             row_reg, row_next;
    logic [IDX_W-1:0]             slice_reg, slice_next;

    logic [IDX_W:0] col_inc, row_inc, slice_inc;
    logic           last_col, last_row, last_slice, volume_done;
    logic           accept, wins;

    // Take a score only while the queue has room for a finished volume
    assign s_tready = push_ready;
    assign accept   = s_tvalid && s_tready;
    assign wins     = $signed(score) > best_score_reg;

    // Counters wrap as soon as they reach or pass the current size
    assign col_inc     = {1'b0, col_reg} + (IDX_W + 1)'(1);
    assign row_inc     = {1'b0, row_reg} + (IDX_W + 1)'(1);
    assign slice_inc   = {1'b0, slice_reg} + (IDX_W + 1)'(1);
    assign last_col    = col_inc >= {1'b0, grid_w};
    assign last_row    = row_inc >= {1'b0, grid_w};
    assign last_slice  = slice_inc >= {1'b0, grid_d};
    assign volume_done = last_col && last_row && last_slice;

    // Strictly greater score takes the place of the best
    always_comb begin
        best_score_next = best_score_reg;
        best_col_next   = best_col_reg;
        best_row_next   = best_row_reg;
        best_slice_next = best_slice_reg;
        have_best_next  = have_best_reg;
        if (wins) begin
            best_score_next = $signed(score);
            best_col_next   = col_reg;
            best_row_next   = row_reg;
            best_slice_next = slice_reg;
            have_best_next  = 1'b1;
        end
    end

    // Step column, row and slice counters
    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        slice_next = slice_reg;
        if (last_col) begin
            col_next = '0;
            if (last_row) begin
                row_next   = '0;
                slice_next = last_slice ? '0 : slice_inc[IDX_W-1:0];
            end else begin
                row_next = row_inc[IDX_W-1:0];
            end
        end else begin
            col_next = col_inc[IDX_W-1:0];
        end
    end

    // Hand the winning cell of a finished volume to the mapper
    assign push_valid = accept && volume_done;
    assign push_data  = {have_best_next, best_slice_next, best_row_next, best_col_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_score_reg <= '0;
            best_col_reg   <= '0;
            best_row_reg   <= '0;
            best_slice_reg <= '0;
            have_best_reg  <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            slice_reg      <= '0;
        end else if (accept) begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            slice_reg <= slice_next;
            if (volume_done) begin
                best_score_reg <= '0;
                best_col_reg   <= '0;
                best_row_reg   <= '0;
                best_slice_reg <= '0;
                have_best_reg  <= 1'b0;
            end else begin
                best_score_reg <= best_score_next;
                best_col_reg   <= best_col_next;
                best_row_reg   <= best_row_next;
                best_slice_reg <= best_slice_next;
                have_best_reg  <= have_best_next;
            end
        end
    end

    a_best_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        have_best_reg == (best_score_reg > 0))
        else $error("best flag disagrees with stored best score");

    a_volume_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |=> (col_reg == '0 && row_reg == '0 && slice_reg == '0
                        && !have_best_reg))
        else $error("volume state not cleared after last cell");

endmodule

@@ rtl/core/hax_back.sv @@
`timescale 1ns / 1ps

module hax_back #(
    parameter int IDX_W = 7
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  logic [3*IDX_W:0]                  q_data,
    input  logic [IDX_W-1:0]                  grid_w,
    input  logic [IDX_W-1:0]                  grid_d,
    input  hax_pkg::bounds_t                  bounds,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic signed [hax_pkg::COORD_W-1:0] coord_x,
    output logic signed [hax_pkg::COORD_W-1:0] coord_y,
    output logic signed [hax_pkg::COORD_W-1:0] coord_z,
    output logic                              found
);

    localparam int COORD_W = hax_pkg::COORD_W;
    localparam int DIFF_W  = hax_pkg::DIFF_W;
    localparam int ODD_W   = IDX_W + 1;
    localparam int NUM_W   = DIFF_W + ODD_W;
    localparam int DEN_W   = IDX_W + 1;
    localparam int SUM_W   = NUM_W + 2;
    localparam int STEP_W  = $clog2(NUM_W);

    localparam logic signed [SUM_W-1:0] V_MIN = SUM_W'(hax_pkg::COORD_MIN);
    localparam logic signed [SUM_W-1:0] V_MAX = SUM_W'(hax_pkg::COORD_MAX);

    hax_pkg::back_state_t state_reg, state_next;

    logic [1:0]                axis_reg, axis_next;
    logic signed [COORD_W-1:0] lb_reg, lb_next;
    logic                      neg_reg, neg_next;
    logic [NUM_W-1:0]          num_reg, num_next;
    logic [DEN_W-1:0]          den_reg, den_next;
    logic [DEN_W-1:0]          rem_reg, rem_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic signed [COORD_W-1:0] cx_reg, cx_next;
    logic signed [COORD_W-1:0] cy_reg, cy_next;
    logic signed [COORD_W-1:0] cz_reg, cz_next;
    logic signed [COORD_W-1:0] ox_reg, ox_next;
    logic signed [COORD_W-1:0] oy_reg, oy_next;
    logic signed [COORD_W-1:0] oz_reg, oz_next;
    logic                      found_reg, found_next;
    logic                      m_valid_reg, m_valid_next;

    logic                      have;
    logic [IDX_W-1:0]          job_col, job_row, job_slice;
    logic signed [COORD_W-1:0] sel_lo, sel_hi;
    logic [IDX_W-1:0]          sel_idx, sel_n;
    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         diff_mag;
    logic [ODD_W-1:0]          odd;
    logic [NUM_W-1:0]          prod;
    logic [DEN_W:0]            rem_sh, rem_sub;
    logic                      rem_ge;
    logic signed [SUM_W-1:0]   q_ext, q_signed, v_sum;
    logic signed [COORD_W-1:0] v_sat;

    assign {have, job_slice, job_row, job_col} = q_data;

    // Pick bounds, index and size of the current axis; box centre if none found
    always_comb begin
        case (axis_reg)
            hax_pkg::AXIS_Y: begin
                sel_lo  = bounds.y_lo;
                sel_hi  = bounds.y_hi;
                sel_idx = have ? job_row : '0;
                sel_n   = have ? grid_w : IDX_W'(1);
            end
            hax_pkg::AXIS_Z: begin
                sel_lo  = bounds.z_lo;
                sel_hi  = bounds.z_hi;
                sel_idx = have ? job_slice : '0;
                sel_n   = have ? grid_d : IDX_W'(1);
            end
            default: begin
                sel_lo  = bounds.x_lo;
                sel_hi  = bounds.x_hi;
                sel_idx = have ? job_col : '0;
                sel_n   = have ? grid_w : IDX_W'(1);
            end
        endcase
    end

    // Numerator magnitude (2i+1)|ub-lb|, sign kept apart
    assign diff     = DIFF_W'(sel_hi) - DIFF_W'(sel_lo);
    assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign odd      = {sel_idx, 1'b1};
    assign prod     = NUM_W'(diff_mag) * NUM_W'(odd);

    // One restoring division step per cycle, quotient shifts into num_reg
    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    // Floor rounding for a negative numerator, then offset and saturate
    assign q_ext    = SUM_W'(num_reg);
    assign q_signed = neg_reg ? (-q_ext - SUM_W'(rem_reg != '0)) : q_ext;
    assign v_sum    = SUM_W'(lb_reg) + q_signed;
    assign v_sat    = (v_sum < V_MIN) ? COORD_W'(V_MIN)
                    : (v_sum > V_MAX) ? COORD_W'(V_MAX)
                    : v_sum[COORD_W-1:0];

    always_comb begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        lb_next      = lb_reg;
        neg_next     = neg_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cz_next      = cz_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        oz_next      = oz_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg;
        q_pop        = 1'b0;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            hax_pkg::BK_IDLE: begin
                if (q_valid) begin
                    axis_next  = hax_pkg::AXIS_X;
                    state_next = hax_pkg::BK_MUL;
                end
            end
            hax_pkg::BK_MUL: begin
                lb_next    = sel_lo;
                neg_next   = diff[DIFF_W-1];
                num_next   = prod;
                den_next   = {sel_n, 1'b0};
                rem_next   = '0;
                step_next  = '0;
                state_next = hax_pkg::BK_DIV;
            end
            hax_pkg::BK_DIV: begin
                rem_next  = rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                num_next  = {num_reg[NUM_W-2:0], rem_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(NUM_W - 1)) begin
                    state_next = hax_pkg::BK_ADD;
                end
            end
            hax_pkg::BK_ADD: begin
                case (axis_reg)
                    hax_pkg::AXIS_X: cx_next = v_sat;
                    hax_pkg::AXIS_Y: cy_next = v_sat;
                    default:         cz_next = v_sat;
                endcase
                if (axis_reg == hax_pkg::AXIS_Z) begin
                    state_next = hax_pkg::BK_SEND;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = hax_pkg::BK_MUL;
                end
            end
            hax_pkg::BK_SEND: begin
                // Load the output register once it is free or being drained
                if (!m_valid_reg || m_tready) begin
                    ox_next      = cx_reg;
                    oy_next      = cy_reg;
                    oz_next      = cz_reg;
                    found_next   = have;
                    m_valid_next = 1'b1;
                    q_pop        = 1'b1;
                    state_next   = hax_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = hax_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hax_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        axis_reg  <= axis_next;
        lb_reg    <= lb_next;
        neg_reg   <= neg_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oz_reg    <= oz_next;
        found_reg <= found_next;
    end

    assign m_tvalid = m_valid_reg;
    assign coord_x  = ox_reg;
    assign coord_y  = oy_reg;
    assign coord_z  = oz_reg;
    assign found    = found_reg;

    a_job_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != hax_pkg::BK_IDLE) |-> q_valid)
        else $error("mapper working without a job at the queue head");

endmodule

@@ rtl/core/heatmap_argmax_to_xyz.sv @@
`timescale 1ns / 1ps

// Volumetric heatmap argmax mapped to box coordinates.
//
// The slave channel carries one Q4.12 score per transfer, in slice, row,
// column order, over grid_width x grid_width x grid_depth cells. Scores are
// taken one per cycle while s_tready is high. The transfer that carries the
// last cell of a volume queues a job, and the master channel later gives
// one transfer with the winning cell centre in Q14.8 (x, y, z in tdata,
// found in tuser). If no score was above zero the box centre is given with
// found low. For each job the mapper runs BK_MUL, BK_DIV and BK_ADD for
// each axis in turn, then loads the output register in BK_SEND once it is
// free. The restoring divider is 25 + clog2(max grid + 1) bits wide; the
// three axes share one multiplier and one divider that retires a quotient
// bit per cycle. A two-entry job queue, freed as a result enters the output
// register, lets later volumes stream in; s_tready falls while it is full,
// after volumes shorter than the mapping time or while m_tready is held
// low. Reset clears the running maximum, the cell counters, the queue and
// the output valid flag, and loads the configuration with its default
// values. Configuration writes take effect at the next clock edge.
module heatmap_argmax_to_xyz #(
    parameter int MAX_GRID_WIDTH = 64,
    parameter int MAX_GRID_DEPTH = 64,
    parameter int SCORE_BITS     = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [SCORE_BITS-1:0] score, zero fill above
    input  logic [((SCORE_BITS + 7) / 8) * 8-1:0] s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [22:0] coord_x, [45:23] coord_y, [68:46] coord_z, zero fill above
    output logic [hax_pkg::M_DATA_W-1:0]          m_tdata,
    // [0] found
    output logic                                  m_tuser,
    input  logic                                  cfg_wr_en,
    input  logic [hax_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [hax_pkg::CFG_DATA_W-1:0]        cfg_wr_data
);

    localparam int MAX_GRID = (MAX_GRID_WIDTH > MAX_GRID_DEPTH) ? MAX_GRID_WIDTH
                            : MAX_GRID_DEPTH;
    localparam int IDX_W    = $clog2(MAX_GRID + 1);
    localparam int JOB_W    = 3 * IDX_W + 1;
    localparam int COORD_W  = hax_pkg::COORD_W;

    logic [hax_pkg::CFG_SIZE_W-1:0] cfg_width_reg;
    logic [hax_pkg::CFG_SIZE_W-1:0] cfg_depth_reg;
    hax_pkg::bounds_t               bounds_reg;

    logic [IDX_W-1:0] grid_w, grid_d;
    logic             push_valid, push_ready, q_valid, q_pop;
    logic [JOB_W-1:0] push_data, q_data;

    logic signed [COORD_W-1:0] coord_x, coord_y, coord_z;
    logic                      found;

    // Write configuration registers; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg   <= hax_pkg::SIZE_RST;
            cfg_depth_reg   <= hax_pkg::SIZE_RST;
            bounds_reg.x_lo <= hax_pkg::BOUND_LO_RST;
            bounds_reg.x_hi <= hax_pkg::BOUND_HI_RST;
            bounds_reg.y_lo <= hax_pkg::BOUND_LO_RST;
            bounds_reg.y_hi <= hax_pkg::BOUND_HI_RST;
            bounds_reg.z_lo <= hax_pkg::BOUND_LO_RST;
            bounds_reg.z_hi <= hax_pkg::BOUND_HI_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                hax_pkg::CFG_GRID_WIDTH:
                    cfg_width_reg <= cfg_wr_data[hax_pkg::CFG_SIZE_W-1:0];
                hax_pkg::CFG_GRID_DEPTH:
                    cfg_depth_reg <= cfg_wr_data[hax_pkg::CFG_SIZE_W-1:0];
                hax_pkg::CFG_X_LOWER: bounds_reg.x_lo <= cfg_wr_data;
                hax_pkg::CFG_X_UPPER: bounds_reg.x_hi <= cfg_wr_data;
                hax_pkg::CFG_Y_LOWER: bounds_reg.y_lo <= cfg_wr_data;
                hax_pkg::CFG_Y_UPPER: bounds_reg.y_hi <= cfg_wr_data;
                hax_pkg::CFG_Z_LOWER: bounds_reg.z_lo <= cfg_wr_data;
                hax_pkg::CFG_Z_UPPER: bounds_reg.z_hi <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Clamp grid sizes to one and to the built maximum
    always_comb begin
        if (cfg_width_reg == '0) begin
            grid_w = IDX_W'(1);
        end else if (int'(cfg_width_reg) > MAX_GRID_WIDTH) begin
            grid_w = IDX_W'(MAX_GRID_WIDTH);
        end else begin
            grid_w = IDX_W'(cfg_width_reg);
        end
        if (cfg_depth_reg == '0) begin
            grid_d = IDX_W'(1);
        end else if (int'(cfg_depth_reg) > MAX_GRID_DEPTH) begin
            grid_d = IDX_W'(MAX_GRID_DEPTH);
        end else begin
            grid_d = IDX_W'(cfg_depth_reg);
        end
    end

    hax_front #(
        .SCORE_BITS (SCORE_BITS),
        .IDX_W      (IDX_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .score      (s_tdata[SCORE_BITS-1:0]),
        .grid_w     (grid_w),
        .grid_d     (grid_d),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    hax_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    hax_back #(
        .IDX_W (IDX_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data),
        .grid_w   (grid_w),
        .grid_d   (grid_d),
        .bounds   (bounds_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .coord_x  (coord_x),
        .coord_y  (coord_y),
        .coord_z  (coord_z),
        .found    (found)
    );

    assign m_tdata = {(hax_pkg::M_DATA_W - 3 * COORD_W)'(0), coord_z, coord_y, coord_x};
    assign m_tuser = found;

endmodule
